// ===== rtl/core/egcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package egcd_pkg;

    localparam int unsigned OPERAND_W = 31;
    localparam int unsigned DIVISOR_W = 31;
    localparam int unsigned COEFF_W   = 32;

    typedef struct packed {
        logic [OPERAND_W-1:0] first_operand;
        logic [OPERAND_W-1:0] second_operand;
    } t_in;

    typedef struct packed {
        logic [DIVISOR_W-1:0]      divisor;
        logic signed [COEFF_W-1:0] coeff_first;
        logic signed [COEFF_W-1:0] coeff_second;
    } t_out;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_X,
        OP_UPD_X,
        OP_MUL_Y,
        OP_UPD_Y
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic b_zero;
        logic div_last;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/core/egcd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module egcd_dp #(
    parameter int unsigned OPERAND_BITS = 31
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire egcd_pkg::t_cmd i_cmd,
    input  wire egcd_pkg::t_in  i_operands,
    output egcd_pkg::t_stat     o_stat,
    output egcd_pkg::t_out      o_result
);
    import egcd_pkg::*;

    localparam int unsigned W  = OPERAND_BITS;
    localparam int unsigned CW = $clog2(W);

    logic [W-1:0]       r_a, n_a;
    logic [W-1:0]       r_b, n_b;
    logic [W-1:0]       r_rem, n_rem;
    logic [W-1:0]       r_quo, n_quo;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [COEFF_W-1:0] r_xp, n_xp, r_x, n_x;
    logic [COEFF_W-1:0] r_yp, n_yp, r_y, n_y;
    logic [COEFF_W-1:0] r_prod, n_prod;

    logic [63:0]        ext_first, ext_second, ext_quo, ext_g;
    logic [W:0]         shifted;
    logic               fits;
    logic [COEFF_W-1:0] q_low, mul_src;

    always_comb begin
        ext_first  = 64'(i_operands.first_operand);
        ext_second = 64'(i_operands.second_operand);
        ext_quo    = 64'(r_quo);
        ext_g      = 64'(r_a);
        q_low      = ext_quo[COEFF_W-1:0];
        mul_src    = (i_cmd.op == OP_MUL_Y) ? r_y : r_x;
        // restoring divide: shift in the next dividend bit, subtract if it fits
        shifted    = {r_rem, r_quo[W-1]};
        fits       = shifted >= {1'b0, r_b};

        n_a    = r_a;
        n_b    = r_b;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_xp   = r_xp;
        n_x    = r_x;
        n_yp   = r_yp;
        n_y    = r_y;
        n_prod = r_prod;

        case (i_cmd.op)
            OP_LOAD: begin
                n_a  = ext_first[W-1:0];
                n_b  = ext_second[W-1:0];
                n_xp = COEFF_W'(1);
                n_x  = '0;
                n_yp = '0;
                n_y  = COEFF_W'(1);
            end
            OP_DIV_INIT: begin
                n_rem = '0;
                n_quo = r_a;
                n_cnt = '0;
            end
            OP_DIV_STEP: begin
                if (fits) begin
                    n_rem = W'(shifted - {1'b0, r_b});
                end else begin
                    n_rem = shifted[W-1:0];
                end
                n_quo = {r_quo[W-2:0], fits};
                n_cnt = r_cnt + CW'(1);
            end
            OP_MUL_X, OP_MUL_Y: begin
                n_prod = COEFF_W'(q_low * mul_src);
            end
            OP_UPD_X: begin
                n_xp = r_x;
                n_x  = r_xp - r_prod;
            end
            OP_UPD_Y: begin
                n_yp = r_y;
                n_y  = r_yp - r_prod;
                n_a  = r_b;
                n_b  = r_rem;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_a    <= n_a;
        r_b    <= n_b;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_xp   <= n_xp;
        r_x    <= n_x;
        r_yp   <= n_yp;
        r_y    <= n_y;
        r_prod <= n_prod;
    end

    assign o_stat.b_zero   = (r_b == '0);
    assign o_stat.div_last = (r_cnt == CW'(W - 1));

    assign o_result.divisor      = ext_g[DIVISOR_W-1:0];
    assign o_result.coeff_first  = r_xp;
    assign o_result.coeff_second = r_yp;

endmodule

`default_nettype wire

// ===== rtl/core/egcd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module egcd_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire egcd_pkg::t_stat i_stat,
    output egcd_pkg::t_cmd       o_cmd,
    output logic                 o_busy,
    output logic                 o_done
);
    import egcd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MUL_X,
        S_UPD_X,
        S_MUL_Y,
        S_UPD_Y
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;

    always_comb begin
        case (r_state)
            S_IDLE:  o_cmd.op = i_start ? OP_LOAD : OP_NONE;
            S_CHECK: o_cmd.op = OP_DIV_INIT;
            S_DIV:   o_cmd.op = OP_DIV_STEP;
            S_MUL_X: o_cmd.op = OP_MUL_X;
            S_UPD_X: o_cmd.op = OP_UPD_X;
            S_MUL_Y: o_cmd.op = OP_MUL_Y;
            S_UPD_Y: o_cmd.op = OP_UPD_Y;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_CHECK;
                        r_busy  <= 1'b1;
                    end
                end
                S_CHECK: begin
                    // remainder reached zero: the previous remainder is the gcd
                    if (i_stat.b_zero) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_stat.div_last) begin
                        r_state <= S_MUL_X;
                    end
                end
                S_MUL_X: r_state <= S_UPD_X;
                S_UPD_X: r_state <= S_MUL_Y;
                S_MUL_Y: r_state <= S_UPD_Y;
                S_UPD_Y: r_state <= S_CHECK;
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/core/extended_gcd_bezout.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Extended Euclid: returns gcd(a, b) and x, y with a*x + b*y = gcd, coefficients as
// 32-bit two's complement. Pulse start while busy is low to load an operand beat;
// busy stays high until the result, which appears on o_result for exactly one cycle
// with o_done high and must be captured then, since it cannot be held off. Before the
// strobe the block runs n Euclid iterations, where n = 0 when b is zero and is at most
// about 45 for 31-bit operands; each iteration is dominated by the restoring divider,
// which retires one quotient bit per cycle, followed by two passes through one shared
// 32x32 multiplier. A new item may be started in the cycle that carries the result
// strobe.
module extended_gcd_bezout #(
    parameter int unsigned OPERAND_BITS = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire egcd_pkg::t_in i_operands,
    output egcd_pkg::t_out     o_result,
    output logic               o_done
);
    import egcd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    egcd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    egcd_dp #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_operands (i_operands),
        .o_stat     (stat),
        .o_result   (o_result)
    );

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_zero_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.divisor != '0) ||
                   (o_result.coeff_first == 32'sd1 && o_result.coeff_second == 32'sd0))
        else $error("zero gcd with wrong coefficients");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import egcd_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 400;
    // Idle watchdog limit: covers the longest item plus the widest sender gap.
    localparam int unsigned IDLE_LIMIT   = 10000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned FIB_LAST     = 46;
    localparam longint unsigned OPERAND_TOP = (64'd1 << OPERAND_W) - 1;

    class bezout_scoreboard;
        t_out        pending_results[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("ERROR %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Iterative extended Euclid on 64-bit words; coefficient updates wrap.
        function t_out euclid_bezout(t_in beat);
            logic [63:0] rem_prev, rem_cur, quot, rem_next;
            logic [63:0] x_prev, x_cur, y_prev, y_cur, x_next, y_next;
            t_out        res;
            rem_prev = 64'(beat.first_operand);
            rem_cur  = 64'(beat.second_operand);
            x_prev   = 64'd1;
            x_cur    = 64'd0;
            y_prev   = 64'd0;
            y_cur    = 64'd1;
            while (rem_cur != 64'd0) begin
                quot     = rem_prev / rem_cur;
                rem_next = rem_prev % rem_cur;
                x_next   = x_prev - quot * x_cur;
                y_next   = y_prev - quot * y_cur;
                x_prev   = x_cur;
                x_cur    = x_next;
                y_prev   = y_cur;
                y_cur    = y_next;
                rem_prev = rem_cur;
                rem_cur  = rem_next;
            end
            res.divisor      = rem_prev[DIVISOR_W-1:0];
            res.coeff_first  = x_prev[COEFF_W-1:0];
            res.coeff_second = y_prev[COEFF_W-1:0];
            return res;
        endfunction

        function void note_operands(t_in beat);
            pending_results.push_back(euclid_bezout(beat));
        endfunction

        task check_result(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing pending: g=%0d x=%0d y=%0d",
                                 got.divisor, got.coeff_first, got.coeff_second));
            end else begin
                want = pending_results.pop_front();
                if (got.divisor !== want.divisor)
                    report($sformatf("divisor got %0d want %0d", got.divisor, want.divisor));
                if (got.coeff_first !== want.coeff_first)
                    report($sformatf("coeff_first got %0d want %0d",
                                     got.coeff_first, want.coeff_first));
                if (got.coeff_second !== want.coeff_second)
                    report($sformatf("coeff_second got %0d want %0d",
                                     got.coeff_second, want.coeff_second));
            end
        endtask

        task flush_leftovers();
            while (pending_results.size() != 0) begin
                report($sformatf("result never came: g=%0d",
                                 pending_results[0].divisor));
                void'(pending_results.pop_front());
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_operands;
    t_out o_result;
    logic o_done;

    bezout_scoreboard sb;
    int unsigned      idle_cycles;

    extended_gcd_bezout u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operands (i_operands),
        .o_result   (o_result),
        .o_done     (o_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_operands(i_operands);
            if (o_done)
                sb.check_result(o_result);
            if ((start && !busy) || o_done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("extended_gcd_bezout: mismatch");
            $finish;
        end
    end

    function automatic longint unsigned fibonacci(int unsigned idx);
        longint unsigned f_lo, f_hi, f_sum;
        f_lo = 0;
        f_hi = 1;
        repeat (idx) begin
            f_sum = f_lo + f_hi;
            f_lo  = f_hi;
            f_hi  = f_sum;
        end
        return f_lo;
    endfunction

    function automatic t_in make_beat(longint unsigned a, longint unsigned b);
        t_in beat;
        beat.first_operand  = a[OPERAND_W-1:0];
        beat.second_operand = b[OPERAND_W-1:0];
        return beat;
    endfunction

    function automatic t_in random_operands();
        longint unsigned a, b, g;
        int unsigned     idx;
        a = OPERAND_W'($urandom);
        b = OPERAND_W'($urandom);
        case ($urandom_range(0, 5))
            0: ;
            1: begin
                // shared factor so the divisor is not almost always one
                g = $urandom_range(2, 1 << 16);
                a = g * $urandom_range(0, int'(OPERAND_TOP / g));
                b = g * $urandom_range(0, int'(OPERAND_TOP / g));
            end
            2: begin
                a = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: a = 0;
                    1: b = 0;
                    2: b = a;
                    default: a = b * $urandom_range(1, 7);
                endcase
            end
            4: begin
                // consecutive Fibonacci numbers take the most steps
                idx = $urandom_range(1, FIB_LAST - 1);
                a = fibonacci(idx + 1);
                b = fibonacci(idx);
                if ($urandom_range(0, 1) == 1) begin
                    g = a;
                    a = b;
                    b = g;
                end
            end
            default: begin
                a = a >> $urandom_range(0, OPERAND_W - 1);
                b = b >> $urandom_range(0, OPERAND_W - 1);
            end
        endcase
        return make_beat(a, b);
    endfunction

    // Hold start until the block takes the beat.
    task send_beat(t_in beat);
        @(negedge i_clk);
        start      = 1'b1;
        i_operands = beat;
        do @(posedge i_clk); while (busy);
    endtask

    task pause(int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start                     = 1'b0;
            i_operands.first_operand  = OPERAND_W'($urandom);
            i_operands.second_operand = OPERAND_W'($urandom);
        end
    endtask

    initial begin
        t_in         directed[$];
        int unsigned sent;
        int unsigned burst;
        sb          = new();
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operands  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed.push_back(make_beat(0, 0));
        directed.push_back(make_beat(12345, 0));
        directed.push_back(make_beat(0, 6789));
        directed.push_back(make_beat(OPERAND_TOP, 0));
        directed.push_back(make_beat(0, OPERAND_TOP));
        directed.push_back(make_beat(OPERAND_TOP, OPERAND_TOP));
        directed.push_back(make_beat(OPERAND_TOP, OPERAND_TOP - 1));
        directed.push_back(make_beat(OPERAND_TOP - 1, OPERAND_TOP));
        directed.push_back(make_beat(1, 1));
        directed.push_back(make_beat(OPERAND_TOP, 1));
        directed.push_back(make_beat(1, OPERAND_TOP));
        directed.push_back(make_beat(fibonacci(FIB_LAST), fibonacci(FIB_LAST - 1)));
        directed.push_back(make_beat(fibonacci(FIB_LAST - 1), fibonacci(FIB_LAST)));
        directed.push_back(make_beat(64'd1 << (OPERAND_W - 1), 64'd1 << 20));
        directed.push_back(make_beat(240, 46));
        directed.push_back(make_beat(46, 240));
        directed.push_back(make_beat(12, 18));
        directed.push_back(make_beat(7, 7));
        directed.push_back(make_beat(64'h2AAA_AAAA, 64'h5555_5555));
        directed.push_back(make_beat(64'h5555_5555, 64'h2AAA_AAAA));
        foreach (directed[i])
            send_beat(directed[i]);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
                send_beat(random_operands());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 40));
        end
        pause(1);

        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.flush_leftovers();
        if (sb.mismatches == 0)
            $display("extended_gcd_bezout: match");
        else
            $display("extended_gcd_bezout: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/egcd_pkg.sv
rtl/core/egcd_dp.sv
rtl/core/egcd_ctrl.sv
rtl/core/extended_gcd_bezout.sv
tb/tb_top.sv
